// ===== rtl/swa_pkg.sv =====
// Shared types and constants of the stop-and-wait ARQ endpoint.
// No dependencies; used by the channel interfaces and the top level.
package swa_pkg;

   localparam int PORT_W  = 16;
   localparam int LEN_W   = 16;
   localparam int SOCK_W  = 8;
   localparam int SENDS_W = 8;
   localparam int TICK_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [SENDS_W-1:0] MAX_SENDS_RESET   = 8'd10;
   localparam logic [TICK_W-1:0]  ACK_TIMEOUT_RESET = 16'd100;
   localparam logic [TICK_W-1:0]  TICK_SATURATE     = 16'hFFFF;

   typedef enum logic [2:0] {
      REQ_BIND    = 3'd0,
      REQ_ACCEPT  = 3'd1,
      REQ_CONNECT = 3'd2,
      REQ_SEND    = 3'd3,
      REQ_PDU     = 3'd4,
      REQ_TICK    = 3'd5,
      REQ_CLOSE   = 3'd6
   } req_code_type;

   typedef enum logic [1:0] {
      CONN_IDLE      = 2'd0,
      CONN_BOUND     = 2'd1,
      CONN_CONNECTED = 2'd2,
      CONN_CLOSED    = 2'd3
   } conn_state_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ERR  = 2'd1,
      STATUS_WAIT = 2'd2,
      STATUS_NONE = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOCK_HANDLE = 2'd0,
      CSR_MAX_SENDS   = 2'd1,
      CSR_ACK_TIMEOUT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [SOCK_W-1:0] sock_id;
      logic [PORT_W-1:0] port_arg;
      logic [LEN_W-1:0]  msg_len;
      logic [PORT_W-1:0] peer_port;
      logic              seq_in;
      logic              ack_num_in;
      logic              syn_in;
      logic              ack_in;
      logic              fin_in;
   } req_word_type;

   typedef struct packed {
      status_type        status;
      logic [LEN_W-1:0]  byte_count;
      logic              tx_valid;
      logic [PORT_W-1:0] tx_src_port;
      logic [PORT_W-1:0] tx_dst_port;
      logic              tx_seq;
      logic              tx_ack_num;
      logic              tx_is_ack;
      logic [LEN_W-1:0]  tx_len;
      logic              deliver;
   } rsp_word_type;

endpackage

// ===== rtl/swa_if.sv =====
// Valid/ready channel interfaces of the stop-and-wait ARQ endpoint:
// request words in, response words out, register writes.
// Depends on swa_pkg for field widths.
interface swa_req_if import swa_pkg::*;;
   logic              valid;
   logic              ready;
   logic [2:0]        req_type;
   logic [SOCK_W-1:0] sock_id;
   logic [PORT_W-1:0] port_arg;
   logic [LEN_W-1:0]  msg_len;
   logic [PORT_W-1:0] peer_port;
   logic              seq_in;
   logic              ack_num_in;
   logic              syn_in;
   logic              ack_in;
   logic              fin_in;

   modport source (output valid, req_type, sock_id, port_arg, msg_len, peer_port,
                   seq_in, ack_num_in, syn_in, ack_in, fin_in, input ready);
   modport sink   (input valid, req_type, sock_id, port_arg, msg_len, peer_port,
                   seq_in, ack_num_in, syn_in, ack_in, fin_in, output ready);
endinterface

interface swa_rsp_if import swa_pkg::*;;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [LEN_W-1:0]  byte_count;
   logic              tx_valid;
   logic [PORT_W-1:0] tx_src_port;
   logic [PORT_W-1:0] tx_dst_port;
   logic              tx_seq;
   logic              tx_ack_num;
   logic              tx_is_ack;
   logic [LEN_W-1:0]  tx_len;
   logic              deliver;

   modport source (output valid, status, byte_count, tx_valid, tx_src_port, tx_dst_port,
                   tx_seq, tx_ack_num, tx_is_ack, tx_len, deliver, input ready);
   modport sink   (input valid, status, byte_count, tx_valid, tx_src_port, tx_dst_port,
                   tx_seq, tx_ack_num, tx_is_ack, tx_len, deliver, output ready);
endinterface

interface swa_csr_if import swa_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/stop_wait_arq_endpoint_unit.sv =====
// Top level of the alternating-bit stop-and-wait ARQ endpoint.
// Depends on swa_pkg and the channel interfaces in swa_if.sv.
//
//   channel    dir   word                                   accepted when
//   req_chan   in    request / PDU arrival / tick           valid & ready
//   rsp_chan   out   status, byte count, tx header, deliver valid & ready
//   csr_chan   in    register index + write data            valid & ready
//
// One request word gives exactly one response word; it passes the input
// register, then the response register. A new word can be taken every
// cycle while rsp_chan is not stalled; the connection/ARQ state updates as
// the word leaves the input register, so the following word sees it. When
// rsp_chan stalls the response register holds and the input register
// fills, then req ready drops. Synchronous reset clears connection state
// and the registers to handle 0, 10 sends, 100-tick timeout. csr_chan is
// always ready; writes are expected only while no word is in flight.
module stop_wait_arq_endpoint_unit import swa_pkg::*; (
   input logic     clock,
   input logic     reset,
   swa_req_if.sink    req_chan,
   swa_rsp_if.source  rsp_chan,
   swa_csr_if.sink    csr_chan
);

   // configuration registers
   logic [SOCK_W-1:0]  sock_handle_ff;
   logic [SENDS_W-1:0] max_sends_ff;
   logic [TICK_W-1:0]  ack_timeout_ff;

   // pipeline registers
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   rsp_word_type out_word_in;

   // endpoint state
   conn_state_type     conn_state_ff, conn_state_in;
   logic [PORT_W-1:0]  local_port_ff, local_port_in;
   logic [PORT_W-1:0]  remote_port_ff, remote_port_in;
   logic               seq_bit_ff, seq_bit_in;
   logic               waiting_ff, waiting_in;
   logic               sent_bit_ff, sent_bit_in;
   logic [SENDS_W-1:0] sends_done_ff, sends_done_in;
   logic [TICK_W-1:0]  wait_ticks_ff, wait_ticks_in;
   logic [LEN_W-1:0]   pending_len_ff, pending_len_in;

   logic advance;
   logic in_take;
   logic handle_match;
   logic good_ack;
   logic data_pdu;
   logic reply_fail;
   logic [TICK_W-1:0] ticks_bumped;

   // the input register moves on whenever the response register is free
   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_take = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign handle_match = (in_word_ff.sock_id == sock_handle_ff);
   assign good_ack = !in_word_ff.syn_in && in_word_ff.ack_in && !in_word_ff.fin_in
                     && (in_word_ff.ack_num_in == sent_bit_ff);
   assign data_pdu = !in_word_ff.syn_in && !in_word_ff.ack_in && !in_word_ff.fin_in;
   assign ticks_bumped = (wait_ticks_ff != TICK_SATURATE) ? wait_ticks_ff + 1'b1
                                                          : wait_ticks_ff;

   // a wrong reply or an expired timer while a send waits
   always_comb begin
      reply_fail = 1'b0;
      if (waiting_ff) begin
         if (in_word_ff.req_type == REQ_PDU) begin
            reply_fail = !good_ack;
         end else if (in_word_ff.req_type == REQ_TICK) begin
            reply_fail = (ticks_bumped >= ack_timeout_ff);
         end
      end
   end

   always_comb begin
      conn_state_in  = conn_state_ff;
      local_port_in  = local_port_ff;
      remote_port_in = remote_port_ff;
      seq_bit_in     = seq_bit_ff;
      waiting_in     = waiting_ff;
      sent_bit_in    = sent_bit_ff;
      sends_done_in  = sends_done_ff;
      wait_ticks_in  = wait_ticks_ff;
      pending_len_in = pending_len_ff;
      out_word_in        = '0;
      out_word_in.status = STATUS_NONE;

      unique case (in_word_ff.req_type)
         REQ_BIND, REQ_ACCEPT, REQ_CONNECT, REQ_SEND, REQ_CLOSE: begin
            out_word_in.status = STATUS_ERR;
            if (!waiting_ff && handle_match) begin
               priority if (in_word_ff.req_type == REQ_BIND && conn_state_ff == CONN_IDLE) begin
                  local_port_in      = in_word_ff.port_arg;
                  conn_state_in      = CONN_BOUND;
                  out_word_in.status = STATUS_OK;
               end else if (in_word_ff.req_type == REQ_ACCEPT
                            && conn_state_ff == CONN_BOUND) begin
                  conn_state_in      = CONN_CONNECTED;
                  out_word_in.status = STATUS_OK;
               end else if (in_word_ff.req_type == REQ_CONNECT
                            && conn_state_ff == CONN_IDLE) begin
                  remote_port_in     = in_word_ff.port_arg;
                  conn_state_in      = CONN_CONNECTED;
                  out_word_in.status = STATUS_OK;
               end else if (in_word_ff.req_type == REQ_SEND
                            && conn_state_ff == CONN_CONNECTED) begin
                  sent_bit_in        = seq_bit_ff;
                  seq_bit_in         = !seq_bit_ff;
                  pending_len_in     = in_word_ff.msg_len;
                  waiting_in         = 1'b1;
                  sends_done_in      = SENDS_W'(1);
                  wait_ticks_in      = '0;
                  out_word_in.status = STATUS_WAIT;
               end else if (in_word_ff.req_type == REQ_CLOSE) begin
                  conn_state_in      = CONN_CLOSED;
                  out_word_in.status = STATUS_OK;
               end else begin
                  out_word_in.status = STATUS_ERR;
               end
            end
         end
         REQ_PDU: begin
            if (waiting_ff) begin
               if (good_ack) begin
                  waiting_in             = 1'b0;
                  wait_ticks_in          = '0;
                  out_word_in.status     = STATUS_OK;
                  out_word_in.byte_count = pending_len_ff;
               end
            end else if (data_pdu) begin
               // ACK every data PDU; deliver only the expected bit
               if (in_word_ff.seq_in == seq_bit_ff) begin
                  out_word_in.deliver = 1'b1;
                  seq_bit_in          = !seq_bit_ff;
               end
               out_word_in.tx_valid    = 1'b1;
               out_word_in.tx_src_port = local_port_ff;
               out_word_in.tx_dst_port = in_word_ff.peer_port;
               out_word_in.tx_ack_num  = in_word_ff.seq_in;
               out_word_in.tx_is_ack   = 1'b1;
            end
         end
         REQ_TICK: begin
            if (waiting_ff) begin
               wait_ticks_in = ticks_bumped;
            end
         end
         default: begin
         end
      endcase

      // resend or give up
      if (reply_fail) begin
         wait_ticks_in = '0;
         if (sends_done_ff < max_sends_ff) begin
            sends_done_in      = sends_done_ff + 1'b1;
            out_word_in.status = STATUS_WAIT;
         end else begin
            waiting_in         = 1'b0;
            out_word_in.status = STATUS_ERR;
         end
      end

      // data header for a first send or a resend
      if (out_word_in.status == STATUS_WAIT) begin
         out_word_in.tx_valid    = 1'b1;
         out_word_in.tx_src_port = local_port_ff;
         out_word_in.tx_dst_port = remote_port_ff;
         out_word_in.tx_seq      = sent_bit_in;
         out_word_in.tx_len      = pending_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         sock_handle_ff <= '0;
         max_sends_ff   <= MAX_SENDS_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         conn_state_ff  <= CONN_IDLE;
         local_port_ff  <= '0;
         remote_port_ff <= '0;
         seq_bit_ff     <= 1'b0;
         waiting_ff     <= 1'b0;
         sent_bit_ff    <= 1'b0;
         sends_done_ff  <= '0;
         wait_ticks_ff  <= '0;
         pending_len_ff <= '0;
      end else begin
         if (in_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               CSR_SOCK_HANDLE: sock_handle_ff <= csr_chan.data[SOCK_W-1:0];
               CSR_MAX_SENDS:   max_sends_ff   <= csr_chan.data[SENDS_W-1:0];
               CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_chan.data[TICK_W-1:0];
               default: begin
               end
            endcase
         end
         if (advance) begin
            conn_state_ff  <= conn_state_in;
            local_port_ff  <= local_port_in;
            remote_port_ff <= remote_port_in;
            seq_bit_ff     <= seq_bit_in;
            waiting_ff     <= waiting_in;
            sent_bit_ff    <= sent_bit_in;
            sends_done_ff  <= sends_done_in;
            wait_ticks_ff  <= wait_ticks_in;
            pending_len_ff <= pending_len_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_word_ff.req_type   <= req_chan.req_type;
         in_word_ff.sock_id    <= req_chan.sock_id;
         in_word_ff.port_arg   <= req_chan.port_arg;
         in_word_ff.msg_len    <= req_chan.msg_len;
         in_word_ff.peer_port  <= req_chan.peer_port;
         in_word_ff.seq_in     <= req_chan.seq_in;
         in_word_ff.ack_num_in <= req_chan.ack_num_in;
         in_word_ff.syn_in     <= req_chan.syn_in;
         in_word_ff.ack_in     <= req_chan.ack_in;
         in_word_ff.fin_in     <= req_chan.fin_in;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_word_ff.status;
   assign rsp_chan.byte_count  = out_word_ff.byte_count;
   assign rsp_chan.tx_valid    = out_word_ff.tx_valid;
   assign rsp_chan.tx_src_port = out_word_ff.tx_src_port;
   assign rsp_chan.tx_dst_port = out_word_ff.tx_dst_port;
   assign rsp_chan.tx_seq      = out_word_ff.tx_seq;
   assign rsp_chan.tx_ack_num  = out_word_ff.tx_ack_num;
   assign rsp_chan.tx_is_ack   = out_word_ff.tx_is_ack;
   assign rsp_chan.tx_len      = out_word_ff.tx_len;
   assign rsp_chan.deliver     = out_word_ff.deliver;

   // a pending send only exists on a connected endpoint
   a_wait_connected: assert property (@(posedge clock) disable iff (reset)
      waiting_ff |-> (conn_state_ff == CONN_CONNECTED))
      else $error("send pending outside connected state");

   // a pending send has made at least one transmission
   a_wait_counted: assert property (@(posedge clock) disable iff (reset)
      waiting_ff |-> (sends_done_ff != '0))
      else $error("send pending with zero transmissions");

   // an accepted send flips the sequence bit away from the one in flight
   a_send_flip: assert property (@(posedge clock) disable iff (reset)
      (advance && !waiting_ff && out_word_in.status == STATUS_WAIT)
      |=> (sent_bit_ff != seq_bit_ff))
      else $error("sequence bit not flipped by send");

   // delivery always rides on an ACK header
   a_deliver_ack: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.deliver) |-> (out_word_ff.tx_valid && out_word_ff.tx_is_ack))
      else $error("delivery without ACK");

   // a stalled response word is not overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> (out_valid_ff && $stable(out_word_ff)))
      else $error("response word lost under stall");

endmodule
